[src/stt_pkg.sv]
// shared types and constants of the source text tokenizer
// no dependencies; used by every module of the block
package stt_pkg;

    localparam int POSITION_WIDTH_DEF = 24;
    localparam int LINE_WIDTH_DEF     = 16;
    localparam int KIND_WIDTH         = 5;
    localparam int DIAG_WIDTH         = 2;
    localparam int QUEUE_DEPTH        = 4;

    // token kinds
    localparam logic [KIND_WIDTH-1:0] TK_EOF     = 5'd0;
    localparam logic [KIND_WIDTH-1:0] TK_PLUS    = 5'd1;
    localparam logic [KIND_WIDTH-1:0] TK_MINUS   = 5'd2;
    localparam logic [KIND_WIDTH-1:0] TK_STAR    = 5'd3;
    localparam logic [KIND_WIDTH-1:0] TK_SLASH   = 5'd4;
    localparam logic [KIND_WIDTH-1:0] TK_DOT     = 5'd5;
    localparam logic [KIND_WIDTH-1:0] TK_COMMA   = 5'd6;
    localparam logic [KIND_WIDTH-1:0] TK_EQUAL   = 5'd7;
    localparam logic [KIND_WIDTH-1:0] TK_LPAREN  = 5'd8;
    localparam logic [KIND_WIDTH-1:0] TK_RPAREN  = 5'd9;
    localparam logic [KIND_WIDTH-1:0] TK_LBRACE  = 5'd10;
    localparam logic [KIND_WIDTH-1:0] TK_RBRACE  = 5'd11;
    localparam logic [KIND_WIDTH-1:0] TK_IDENT   = 5'd12;
    localparam logic [KIND_WIDTH-1:0] TK_NUMBER  = 5'd13;
    localparam logic [KIND_WIDTH-1:0] TK_STRING  = 5'd14;
    localparam logic [KIND_WIDTH-1:0] TK_ERROR   = 5'd15;
    localparam logic [KIND_WIDTH-1:0] TK_UNKNOWN = 5'd16;

    // diagnostics
    localparam logic [DIAG_WIDTH-1:0] DIAG_NONE    = 2'd0;
    localparam logic [DIAG_WIDTH-1:0] DIAG_ILLEGAL = 2'd1;
    localparam logic [DIAG_WIDTH-1:0] DIAG_UNTERM  = 2'd2;

    typedef enum logic [3:0] {
        CC_NUL,
        CC_CR,
        CC_LF,
        CC_BLANK,
        CC_OP,
        CC_DOT,
        CC_QUOTE,
        CC_UNDER,
        CC_ALPHA,
        CC_DIGIT,
        CC_OTHER
    } t_char_class;

    typedef struct packed {
        t_char_class           cls;
        logic [KIND_WIDTH-1:0] op_kind;
    } t_char_info;

endpackage

[src/stt_front.sv]
// front end: takes source bytes and classifies them into character classes
// depends on stt_pkg; feeds stt_queue
module stt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_full,
    output logic               o_push,
    output stt_pkg::t_char_info o_push_info
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic stt_pkg::t_char_info classify(input logic [7:0] c);
        stt_pkg::t_char_info info;
        info.op_kind = stt_pkg::TK_EOF;
        info.cls     = stt_pkg::CC_OTHER;
        case (c)
            CH_NUL:   info.cls = stt_pkg::CC_NUL;
            CH_CR:    info.cls = stt_pkg::CC_CR;
            CH_LF:    info.cls = stt_pkg::CC_LF;
            CH_TAB,
            CH_SPACE: info.cls = stt_pkg::CC_BLANK;
            CH_QUOTE: info.cls = stt_pkg::CC_QUOTE;
            CH_UNDER: info.cls = stt_pkg::CC_UNDER;
            CH_DOT: begin
                info.cls     = stt_pkg::CC_DOT;
                info.op_kind = stt_pkg::TK_DOT;
            end
            "+": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_PLUS;   end
            "-": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_MINUS;  end
            "*": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_STAR;   end
            "/": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_SLASH;  end
            ",": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_COMMA;  end
            "=": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_EQUAL;  end
            "(": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_LPAREN; end
            ")": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_RPAREN; end
            "{": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_LBRACE; end
            "}": begin info.cls = stt_pkg::CC_OP; info.op_kind = stt_pkg::TK_RBRACE; end
            default: begin
                if (c >= "0" && c <= "9") begin
                    info.cls = stt_pkg::CC_DIGIT;
                end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                    info.cls = stt_pkg::CC_ALPHA;
                end else begin
                    info.cls = stt_pkg::CC_OTHER;
                end
            end
        endcase
        return info;
    endfunction

    logic                r_valid;
    stt_pkg::t_char_info r_info;
    logic                accept;

    assign o_stall     = r_valid && i_full;
    assign accept      = i_valid && !o_stall;
    assign o_push      = r_valid && !i_full;
    assign o_push_info = r_info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_info <= classify(i_char_code);
        end
    end

endmodule

[src/stt_queue.sv]
// short queue of classified bytes between the front end and the lexer
// depends on stt_pkg for the entry type and depth
module stt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  stt_pkg::t_char_info i_push_info,
    output logic                o_full,
    output logic                o_valid,
    output stt_pkg::t_char_info o_head,
    input  logic                i_pop
);

    localparam int PTR_W = $clog2(stt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(stt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(stt_pkg::QUEUE_DEPTH - 1);

    stt_pkg::t_char_info r_entry [stt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_W'(stt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_info;
        end
    end

endmodule

[src/stt_back.sv]
// back end: lexer state machine with position counters and the token output register
// depends on stt_pkg; reads classified bytes from stt_queue
module stt_back #(
    parameter int POSITION_WIDTH = stt_pkg::POSITION_WIDTH_DEF,
    parameter int LINE_WIDTH     = stt_pkg::LINE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  stt_pkg::t_char_info            i_q_info,
    output logic                           o_q_pop,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [stt_pkg::KIND_WIDTH-1:0] o_token_kind,
    output logic [POSITION_WIDTH-1:0]      o_start_position,
    output logic [POSITION_WIDTH-1:0]      o_end_position,
    output logic [LINE_WIDTH-1:0]          o_start_line,
    output logic [LINE_WIDTH-1:0]          o_start_column,
    output logic [LINE_WIDTH-1:0]          o_end_line,
    output logic [LINE_WIDTH-1:0]          o_end_column,
    output logic [stt_pkg::DIAG_WIDTH-1:0] o_diag_code,
    output logic                           o_last_of_run
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_AFTER_CR,
        M_IDENT,
        M_INT,
        M_FRAC,
        M_STRING
    } t_mode;

    localparam logic [LINE_WIDTH-1:0]     LC_ONE  = LINE_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] POS_TWO = POSITION_WIDTH'(2);

    function automatic logic [LINE_WIDTH-1:0] sat_add(input logic [LINE_WIDTH-1:0] v,
                                                      input logic [1:0] inc);
        logic [LINE_WIDTH:0] s;
        s = {1'b0, v} + {{(LINE_WIDTH-1){1'b0}}, inc};
        return s[LINE_WIDTH] ? {LINE_WIDTH{1'b1}} : s[LINE_WIDTH-1:0];
    endfunction

    // classes that give a record of their own when seen in idle mode
    function automatic logic idle_emits(input stt_pkg::t_char_class c);
        return (c == stt_pkg::CC_NUL) || (c == stt_pkg::CC_OP) ||
               (c == stt_pkg::CC_DOT) || (c == stt_pkg::CC_OTHER);
    endfunction

    // lexer state
    t_mode                     r_mode;
    logic                      r_held_valid;
    logic                      r_held_dot;
    logic                      r_replay;
    logic [POSITION_WIDTH-1:0] r_pos;
    logic [LINE_WIDTH-1:0]     r_line;
    logic [LINE_WIDTH-1:0]     r_col;
    logic [POSITION_WIDTH-1:0] r_tok_pos;
    logic [LINE_WIDTH-1:0]     r_tok_line;
    logic [LINE_WIDTH-1:0]     r_tok_col;

    t_mode                     n_mode;
    logic                      n_held_valid;
    logic                      n_held_dot;
    logic                      n_replay;
    logic [POSITION_WIDTH-1:0] n_pos;
    logic [LINE_WIDTH-1:0]     n_line;
    logic [LINE_WIDTH-1:0]     n_col;
    logic [POSITION_WIDTH-1:0] n_tok_pos;
    logic [LINE_WIDTH-1:0]     n_tok_line;
    logic [LINE_WIDTH-1:0]     n_tok_col;

    // output register
    logic                           r_out_valid;
    logic [stt_pkg::KIND_WIDTH-1:0] r_out_kind;
    logic [POSITION_WIDTH-1:0]      r_out_sp;
    logic [POSITION_WIDTH-1:0]      r_out_ep;
    logic [LINE_WIDTH-1:0]          r_out_sl;
    logic [LINE_WIDTH-1:0]          r_out_sc;
    logic [LINE_WIDTH-1:0]          r_out_el;
    logic [LINE_WIDTH-1:0]          r_out_ec;
    logic [stt_pkg::DIAG_WIDTH-1:0] r_out_diag;
    logic                           r_out_last;

    // one step of the lexer
    stt_pkg::t_char_class           cur_cls;
    logic [stt_pkg::KIND_WIDTH-1:0] cur_op;
    logic                           have_byte;
    logic                           out_ready;
    logic                           fire;
    logic                           do_idle;
    logic                           step_emit;
    logic                           step_consume;
    logic                           step_fallback;
    logic [stt_pkg::KIND_WIDTH-1:0] e_kind;
    logic [POSITION_WIDTH-1:0]      e_sp;
    logic [POSITION_WIDTH-1:0]      e_ep;
    logic [LINE_WIDTH-1:0]          e_sl;
    logic [LINE_WIDTH-1:0]          e_sc;
    logic [LINE_WIDTH-1:0]          e_el;
    logic [LINE_WIDTH-1:0]          e_ec;
    logic [stt_pkg::DIAG_WIDTH-1:0] e_diag;
    logic                           e_last;
    logic [POSITION_WIDTH-1:0]      pos1;
    logic [POSITION_WIDTH-1:0]      pos2;
    logic [LINE_WIDTH-1:0]          col1;
    logic [LINE_WIDTH-1:0]          col2;
    logic [LINE_WIDTH-1:0]          line1;

    assign pos1  = r_pos + POS_ONE;
    assign pos2  = r_pos + POS_TWO;
    assign col1  = sat_add(r_col, 2'd1);
    assign col2  = sat_add(r_col, 2'd2);
    assign line1 = sat_add(r_line, 2'd1);

    // a replayed held byte goes ahead of the queue head, which is not popped
    assign cur_cls   = r_replay ? (r_held_dot ? stt_pkg::CC_DOT : stt_pkg::CC_UNDER)
                                : i_q_info.cls;
    assign cur_op    = r_replay ? stt_pkg::TK_DOT : i_q_info.op_kind;
    assign have_byte = r_replay || i_q_valid;
    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = have_byte && (!step_emit || out_ready);
    assign o_q_pop   = fire && step_consume && !r_replay;

    always_comb begin
        n_mode        = r_mode;
        n_held_valid  = r_held_valid;
        n_held_dot    = r_held_dot;
        n_replay      = r_replay;
        n_pos         = r_pos;
        n_line        = r_line;
        n_col         = r_col;
        n_tok_pos     = r_tok_pos;
        n_tok_line    = r_tok_line;
        n_tok_col     = r_tok_col;
        do_idle       = 1'b0;
        step_emit     = 1'b0;
        step_consume  = 1'b0;
        step_fallback = 1'b0;
        e_kind        = stt_pkg::TK_EOF;
        e_sp          = r_tok_pos;
        e_ep          = r_pos;
        e_sl          = r_tok_line;
        e_sc          = r_tok_col;
        e_el          = r_line;
        e_ec          = r_col;
        e_diag        = stt_pkg::DIAG_NONE;

        if (r_replay) begin
            n_replay = 1'b0;
            do_idle  = 1'b1;
        end else begin
            case (r_mode)
                M_AFTER_CR: begin
                    if (cur_cls == stt_pkg::CC_LF) begin
                        // LF of a CRLF pair
                        n_mode       = M_IDLE;
                        n_pos        = pos1;
                        step_consume = 1'b1;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (cur_cls == stt_pkg::CC_UNDER || cur_cls == stt_pkg::CC_ALPHA ||
                        cur_cls == stt_pkg::CC_DIGIT) begin
                        n_pos        = pos1;
                        n_col        = col1;
                        step_consume = 1'b1;
                    end else begin
                        step_emit = 1'b1;
                        e_kind    = stt_pkg::TK_IDENT;
                        n_mode    = M_IDLE;
                    end
                end
                M_FRAC: begin
                    if (cur_cls == stt_pkg::CC_UNDER || cur_cls == stt_pkg::CC_DIGIT) begin
                        n_pos        = pos1;
                        n_col        = col1;
                        step_consume = 1'b1;
                    end else begin
                        step_emit = 1'b1;
                        e_kind    = stt_pkg::TK_NUMBER;
                        n_mode    = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (cur_cls == stt_pkg::CC_QUOTE) begin
                        step_emit    = 1'b1;
                        e_kind       = stt_pkg::TK_STRING;
                        e_ep         = pos1;
                        e_ec         = col1;
                        n_pos        = pos1;
                        n_col        = col1;
                        n_mode       = M_IDLE;
                        step_consume = 1'b1;
                    end else if (cur_cls == stt_pkg::CC_NUL) begin
                        step_emit = 1'b1;
                        e_kind    = stt_pkg::TK_ERROR;
                        e_diag    = stt_pkg::DIAG_UNTERM;
                        n_mode    = M_IDLE;
                    end else begin
                        // newlines inside strings only move the column
                        n_pos        = pos1;
                        n_col        = col1;
                        step_consume = 1'b1;
                    end
                end
                M_INT: begin
                    if (r_held_valid) begin
                        if (!r_held_dot && cur_cls != stt_pkg::CC_DOT) begin
                            // held underscore stays in the number
                            n_held_valid = 1'b0;
                            n_pos        = pos1;
                            n_col        = col1;
                            if (cur_cls == stt_pkg::CC_DIGIT) begin
                                n_pos        = pos2;
                                n_col        = col2;
                                step_consume = 1'b1;
                            end else if (cur_cls == stt_pkg::CC_UNDER) begin
                                n_held_valid = 1'b1;
                                n_held_dot   = 1'b0;
                                step_consume = 1'b1;
                            end else begin
                                step_emit = 1'b1;
                                e_kind    = stt_pkg::TK_NUMBER;
                                e_ep      = pos1;
                                e_ec      = col1;
                                n_mode    = M_IDLE;
                            end
                        end else if (r_held_dot && cur_cls == stt_pkg::CC_DIGIT) begin
                            n_held_valid = 1'b0;
                            n_pos        = pos2;
                            n_col        = col2;
                            n_mode       = M_FRAC;
                            step_consume = 1'b1;
                        end else begin
                            // number ends before the held byte, which is lexed again
                            step_emit     = 1'b1;
                            step_fallback = 1'b1;
                            e_kind        = stt_pkg::TK_NUMBER;
                            n_mode        = M_IDLE;
                            n_held_valid  = 1'b0;
                            n_replay      = 1'b1;
                        end
                    end else if (cur_cls == stt_pkg::CC_DIGIT) begin
                        n_pos        = pos1;
                        n_col        = col1;
                        step_consume = 1'b1;
                    end else if (cur_cls == stt_pkg::CC_UNDER || cur_cls == stt_pkg::CC_DOT) begin
                        n_held_valid = 1'b1;
                        n_held_dot   = (cur_cls == stt_pkg::CC_DOT);
                        step_consume = 1'b1;
                    end else begin
                        step_emit = 1'b1;
                        e_kind    = stt_pkg::TK_NUMBER;
                        n_mode    = M_IDLE;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
        end

        if (do_idle) begin
            n_held_valid = 1'b0;
            n_mode       = M_IDLE;
            step_consume = 1'b1;
            e_sp         = r_pos;
            e_sl         = r_line;
            e_sc         = r_col;
            case (cur_cls)
                stt_pkg::CC_CR: begin
                    n_pos  = pos1;
                    n_line = line1;
                    n_col  = LC_ONE;
                    n_mode = M_AFTER_CR;
                end
                stt_pkg::CC_LF: begin
                    n_pos  = pos1;
                    n_line = line1;
                    n_col  = LC_ONE;
                end
                stt_pkg::CC_BLANK: begin
                    n_pos = pos1;
                    n_col = col1;
                end
                stt_pkg::CC_NUL: begin
                    step_emit = 1'b1;
                    e_kind    = stt_pkg::TK_EOF;
                    n_pos     = pos1;
                    n_col     = col1;
                end
                stt_pkg::CC_OP,
                stt_pkg::CC_DOT: begin
                    step_emit = 1'b1;
                    e_kind    = cur_op;
                    e_ep      = pos1;
                    e_ec      = col1;
                    n_pos     = pos1;
                    n_col     = col1;
                end
                stt_pkg::CC_QUOTE,
                stt_pkg::CC_UNDER,
                stt_pkg::CC_ALPHA,
                stt_pkg::CC_DIGIT: begin
                    n_tok_pos  = r_pos;
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                    n_pos      = pos1;
                    n_col      = col1;
                    if (cur_cls == stt_pkg::CC_QUOTE) begin
                        n_mode = M_STRING;
                    end else if (cur_cls == stt_pkg::CC_DIGIT) begin
                        n_mode = M_INT;
                    end else begin
                        n_mode = M_IDENT;
                    end
                end
                default: begin
                    step_emit = 1'b1;
                    e_kind    = stt_pkg::TK_UNKNOWN;
                    e_diag    = stt_pkg::DIAG_ILLEGAL;
                    n_pos     = pos1;
                    n_col     = col1;
                end
            endcase
        end
    end

    // a record that leaves its byte in the queue is the last only if idle mode
    // makes nothing of that byte; a fallback always has the held byte to follow
    always_comb begin
        if (step_consume && !r_replay) begin
            e_last = 1'b1;
        end else if (step_fallback) begin
            e_last = 1'b0;
        end else begin
            e_last = !idle_emits(i_q_info.cls);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_held_valid <= 1'b0;
            r_held_dot   <= 1'b0;
            r_replay     <= 1'b0;
            r_pos        <= '0;
            r_line       <= LC_ONE;
            r_col        <= LC_ONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_mode       <= n_mode;
                r_held_valid <= n_held_valid;
                r_held_dot   <= n_held_dot;
                r_replay     <= n_replay;
                r_pos        <= n_pos;
                r_line       <= n_line;
                r_col        <= n_col;
                r_tok_pos    <= n_tok_pos;
                r_tok_line   <= n_tok_line;
                r_tok_col    <= n_tok_col;
            end
            if (fire && step_emit) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= e_kind;
                r_out_sp    <= e_sp;
                r_out_ep    <= e_ep;
                r_out_sl    <= e_sl;
                r_out_sc    <= e_sc;
                r_out_el    <= e_el;
                r_out_ec    <= e_ec;
                r_out_diag  <= e_diag;
                r_out_last  <= e_last;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_token_kind     = r_out_kind;
    assign o_start_position = r_out_sp;
    assign o_end_position   = r_out_ep;
    assign o_start_line     = r_out_sl;
    assign o_start_column   = r_out_sc;
    assign o_end_line       = r_out_el;
    assign o_end_column     = r_out_ec;
    assign o_diag_code      = r_out_diag;
    assign o_last_of_run    = r_out_last;

endmodule

[src/source_text_tokenizer_core.sv]
// Streaming tokenizer: one ASCII source byte in per item, token records out; byte 0 ends the
// text. The front end takes one byte every cycle unless the queue is full, and classifies
// it; a four-entry queue separates it from the lexer, which runs one step per cycle while it
// has a byte and no record waits on a stalled output, and writes at most one record per step
// into the output register. A byte inside a token or blank space takes one step; a byte that
// ends a token, other than a closing quote, takes one step more. The byte after a number
// that ends on a held '.' takes three steps, and a '.' after a held '_' four, since the held
// byte is lexed again in a step of its own. The input keeps one byte per cycle while the
// queue soaks up these extra steps and records are taken at once; a long run of token ends
// or a stalled output fills the queue and stalls the input. Line and column counts saturate,
// byte positions wrap. Depends on stt_pkg, stt_front, stt_queue and stt_back.
module source_text_tokenizer_core #(
    parameter int POSITION_WIDTH = stt_pkg::POSITION_WIDTH_DEF,
    parameter int LINE_WIDTH     = stt_pkg::LINE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_char_code,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [stt_pkg::KIND_WIDTH-1:0] o_token_kind,
    output logic [POSITION_WIDTH-1:0]      o_start_position,
    output logic [POSITION_WIDTH-1:0]      o_end_position,
    output logic [LINE_WIDTH-1:0]          o_start_line,
    output logic [LINE_WIDTH-1:0]          o_start_column,
    output logic [LINE_WIDTH-1:0]          o_end_line,
    output logic [LINE_WIDTH-1:0]          o_end_column,
    output logic [stt_pkg::DIAG_WIDTH-1:0] o_diag_code,
    output logic                           o_last_of_run
);

    logic                push;
    stt_pkg::t_char_info push_info;
    logic                q_full;
    logic                q_valid;
    stt_pkg::t_char_info q_head;
    logic                q_pop;

    stt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_full      (q_full),
        .o_push      (push),
        .o_push_info (push_info)
    );

    stt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_info (push_info),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .i_pop       (q_pop)
    );

    stt_back #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .LINE_WIDTH     (LINE_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_info         (q_head),
        .o_q_pop          (q_pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_token_kind     (o_token_kind),
        .o_start_position (o_start_position),
        .o_end_position   (o_end_position),
        .o_start_line     (o_start_line),
        .o_start_column   (o_start_column),
        .o_end_line       (o_end_line),
        .o_end_column     (o_end_column),
        .o_diag_code      (o_diag_code),
        .o_last_of_run    (o_last_of_run)
    );

    // nothing left over in the output register after reset
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("token output valid after reset");

    // an unterminated string is always followed by the eof record of the same byte
    a_unterm_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_diag_code == stt_pkg::DIAG_UNTERM
        |-> o_token_kind == stt_pkg::TK_ERROR && !o_last_of_run)
        else $error("unterminated string record malformed");

    // eof closes its run and has size zero
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == stt_pkg::TK_EOF
        |-> o_last_of_run && o_start_position == o_end_position
            && o_diag_code == stt_pkg::DIAG_NONE)
        else $error("eof record malformed");

    // the queue only pops with a byte present
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

[sim/tb.sv]
// self-checking testbench for source_text_tokenizer_core: drives source bytes,
// predicts the token records in a local lexer and compares them as they come out
// depends on stt_pkg and source_text_tokenizer_core
module tb;

    localparam int POS_W          = stt_pkg::POSITION_WIDTH_DEF;
    localparam int LN_W           = stt_pkg::LINE_WIDTH_DEF;
    localparam int KIND_W         = stt_pkg::KIND_WIDTH;
    localparam int DIAG_W         = stt_pkg::DIAG_WIDTH;
    localparam int LN_MAX         = (1 << LN_W) - 1;
    localparam int RANDOM_BYTES   = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int FLUSH_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_AFTER_CR,
        LX_WORD,
        LX_INT,
        LX_FRAC,
        LX_QUOTED
    } t_lex_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  end_pos;
        logic [LN_W-1:0]   start_line;
        logic [LN_W-1:0]   start_col;
        logic [LN_W-1:0]   end_line;
        logic [LN_W-1:0]   end_col;
        logic [DIAG_W-1:0] diag;
        logic              last;
    } t_token_rec;

    typedef struct packed {
        logic [7:0] ch;
        logic       drain;
    } t_source_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_char_code;
    logic              o_valid;
    logic              i_stall;
    logic [KIND_W-1:0] o_token_kind;
    logic [POS_W-1:0]  o_start_position;
    logic [POS_W-1:0]  o_end_position;
    logic [LN_W-1:0]   o_start_line;
    logic [LN_W-1:0]   o_start_column;
    logic [LN_W-1:0]   o_end_line;
    logic [LN_W-1:0]   o_end_column;
    logic [DIAG_W-1:0] o_diag_code;
    logic              o_last_of_run;

    source_text_tokenizer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_code      (i_char_code),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_token_kind     (o_token_kind),
        .o_start_position (o_start_position),
        .o_end_position   (o_end_position),
        .o_start_line     (o_start_line),
        .o_start_column   (o_start_column),
        .o_end_line       (o_end_line),
        .o_end_column     (o_end_column),
        .o_diag_code      (o_diag_code),
        .o_last_of_run    (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // lexer shadow state
    t_lex_mode        lx_mode = LX_IDLE;
    logic [7:0]       hold_byte = 8'h00;
    logic             hold_valid = 1'b0;
    logic [POS_W-1:0] lx_pos = '0;
    logic [LN_W-1:0]  lx_line = 1;
    logic [LN_W-1:0]  lx_col = 1;
    logic [POS_W-1:0] tok_pos = '0;
    logic [LN_W-1:0]  tok_line = '0;
    logic [LN_W-1:0]  tok_col = '0;

    t_token_rec   step_recs [0:3];
    int           step_n;
    t_token_rec   tokens_due [$];
    t_source_byte byte_queue [$];
    t_source_byte head_byte;

    logic drain_pending = 1'b0;
    logic byte_taken = 1'b0;
    int   send_gap = 0;
    int   send_quiet = 0;
    int   settle_cnt = 0;
    int   stall_left = 0;
    int   sink_quiet = 0;
    int   idle_cycles = 0;
    int   mismatches = 0;
    int   bytes_sent = 0;
    int   records_seen = 0;
    logic kinds_seen [0:31];
    t_token_rec seen_rec;
    t_token_rec want_rec;

    function automatic logic [LN_W-1:0] sat_inc(input logic [LN_W-1:0] v);
        return (v == LN_W'(LN_MAX)) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
        case (c)
            "+": return stt_pkg::TK_PLUS;
            "-": return stt_pkg::TK_MINUS;
            "*": return stt_pkg::TK_STAR;
            "/": return stt_pkg::TK_SLASH;
            ".": return stt_pkg::TK_DOT;
            ",": return stt_pkg::TK_COMMA;
            "=": return stt_pkg::TK_EQUAL;
            "(": return stt_pkg::TK_LPAREN;
            ")": return stt_pkg::TK_RPAREN;
            "{": return stt_pkg::TK_LBRACE;
            "}": return stt_pkg::TK_RBRACE;
            default: return stt_pkg::TK_EOF;
        endcase
    endfunction

    function automatic void step_col();
        lx_pos = lx_pos + 1'b1;
        lx_col = sat_inc(lx_col);
    endfunction

    function automatic void step_line();
        lx_pos  = lx_pos + 1'b1;
        lx_line = sat_inc(lx_line);
        lx_col  = 1;
    endfunction

    function automatic void add_rec(input logic [KIND_W-1:0] k,
                                    input logic [POS_W-1:0] sp, input logic [POS_W-1:0] ep,
                                    input logic [LN_W-1:0] sl, input logic [LN_W-1:0] sc,
                                    input logic [LN_W-1:0] el, input logic [LN_W-1:0] ec,
                                    input logic [DIAG_W-1:0] dg);
        t_token_rec r;
        r.kind       = k;
        r.start_pos  = sp;
        r.end_pos    = ep;
        r.start_line = sl;
        r.start_col  = sc;
        r.end_line   = el;
        r.end_col    = ec;
        r.diag       = dg;
        r.last       = 1'b0;
        step_recs[step_n] = r;
        step_n++;
    endfunction

    function automatic void add_span(input logic [KIND_W-1:0] k,
                                     input logic [DIAG_W-1:0] dg);
        add_rec(k, tok_pos, lx_pos, tok_line, tok_col, lx_line, lx_col, dg);
    endfunction

    function automatic void open_tok(input t_lex_mode m);
        tok_pos  = lx_pos;
        tok_line = lx_line;
        tok_col  = lx_col;
        step_col();
        lx_mode = m;
    endfunction

    function automatic void lex_idle(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        k = op_kind(c);
        lx_mode = LX_IDLE;
        if (c == CH_CR) begin
            step_line();
            lx_mode = LX_AFTER_CR;
        end else if (c == CH_LF) begin
            step_line();
        end else if (c == CH_TAB || c == CH_SPACE) begin
            step_col();
        end else if (c == CH_NUL) begin
            add_rec(stt_pkg::TK_EOF, lx_pos, lx_pos, lx_line, lx_col, lx_line, lx_col,
                    stt_pkg::DIAG_NONE);
            step_col();
        end else if (k != stt_pkg::TK_EOF) begin
            add_rec(k, lx_pos, lx_pos + 1'b1, lx_line, lx_col, lx_line, sat_inc(lx_col),
                    stt_pkg::DIAG_NONE);
            step_col();
        end else if (c == CH_QUOTE) begin
            open_tok(LX_QUOTED);
        end else if (c == CH_UNDER || is_alpha(c)) begin
            open_tok(LX_WORD);
        end else if (is_digit(c)) begin
            open_tok(LX_INT);
        end else begin
            add_rec(stt_pkg::TK_UNKNOWN, lx_pos, lx_pos, lx_line, lx_col, lx_line, lx_col,
                    stt_pkg::DIAG_ILLEGAL);
            step_col();
        end
    endfunction

    // one source byte into the shadow lexer; bytes that must be lexed again go on a stack
    task automatic lex_byte(input logic [7:0] c);
        logic [7:0] redo [0:3];
        int         depth;
        int         i;
        logic [7:0] b;
        logic [7:0] h;
        t_token_rec r;
        step_n   = 0;
        redo[0]  = c;
        depth    = 1;
        while (depth > 0) begin
            depth--;
            b = redo[depth];
            case (lx_mode)
                LX_AFTER_CR: begin
                    lx_mode = LX_IDLE;
                    if (b == CH_LF) lx_pos = lx_pos + 1'b1;
                    else lex_idle(b);
                end
                LX_WORD: begin
                    if (b == CH_UNDER || is_alpha(b) || is_digit(b)) begin
                        step_col();
                    end else begin
                        add_span(stt_pkg::TK_IDENT, stt_pkg::DIAG_NONE);
                        lex_idle(b);
                    end
                end
                LX_INT: begin
                    if (hold_valid) begin
                        h          = hold_byte;
                        hold_valid = 1'b0;
                        hold_byte  = 8'h00;
                        if (h == CH_UNDER && b != CH_DOT) begin
                            step_col();
                            redo[depth] = b;
                            depth++;
                        end else if (h == CH_DOT && is_digit(b)) begin
                            step_col();
                            step_col();
                            lx_mode = LX_FRAC;
                        end else begin
                            // number ends; held byte then current byte are lexed afresh
                            add_span(stt_pkg::TK_NUMBER, stt_pkg::DIAG_NONE);
                            lx_mode       = LX_IDLE;
                            redo[depth]   = b;
                            redo[depth+1] = h;
                            depth += 2;
                        end
                    end else if (is_digit(b)) begin
                        step_col();
                    end else if (b == CH_UNDER || b == CH_DOT) begin
                        hold_byte  = b;
                        hold_valid = 1'b1;
                    end else begin
                        add_span(stt_pkg::TK_NUMBER, stt_pkg::DIAG_NONE);
                        lx_mode = LX_IDLE;
                        redo[depth] = b;
                        depth++;
                    end
                end
                LX_FRAC: begin
                    if (b == CH_UNDER || is_digit(b)) begin
                        step_col();
                    end else begin
                        add_span(stt_pkg::TK_NUMBER, stt_pkg::DIAG_NONE);
                        lx_mode = LX_IDLE;
                        redo[depth] = b;
                        depth++;
                    end
                end
                LX_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        step_col();
                        add_span(stt_pkg::TK_STRING, stt_pkg::DIAG_NONE);
                        lx_mode = LX_IDLE;
                    end else if (b == CH_NUL) begin
                        add_span(stt_pkg::TK_ERROR, stt_pkg::DIAG_UNTERM);
                        lex_idle(b);
                    end else begin
                        step_col();
                    end
                end
                default: begin
                    hold_valid = 1'b0;
                    lex_idle(b);
                end
            endcase
        end
        for (i = 0; i < step_n; i++) begin
            r      = step_recs[i];
            r.last = (i == step_n - 1);
            tokens_due.insert(tokens_due.size(), r);
        end
    endtask

    function automatic string rec_text(input t_token_rec r);
        return $sformatf("kind=%0d pos=%0d..%0d at %0d:%0d..%0d:%0d diag=%0d last=%0b",
                         r.kind, r.start_pos, r.end_pos, r.start_line, r.start_col,
                         r.end_line, r.end_col, r.diag, r.last);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    function automatic int next_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stimulus building
    task automatic add_byte(input logic [7:0] b);
        t_source_byte s;
        s.ch    = b;
        s.drain = drain_pending;
        byte_queue.insert(byte_queue.size(), s);
        drain_pending = 1'b0;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_alpha();
        return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return rand_alpha();
        if (r < 8) return rand_digit();
        return CH_UNDER;
    endfunction

    task automatic add_random_token();
        string      ops;
        int         sel;
        int         n;
        int         i;
        int         r;
        logic [7:0] ch;
        ops = "+-*/.,=(){}";
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            add_byte(ops[$urandom_range(0, 10)]);
        end else if (sel < 35) begin
            add_byte(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_alpha());
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) add_byte(rand_word_char());
            if ($urandom_range(0, 9) < 6) add_byte(CH_SPACE);
        end else if (sel < 60) begin
            add_byte(rand_digit());
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) add_byte(($urandom_range(0, 3) == 0) ? CH_UNDER : rand_digit());
            if ($urandom_range(0, 9) < 4) begin
                add_byte(CH_DOT);
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    add_byte(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_digit());
            end
            // trailing lookahead byte followed by whatever comes next
            if ($urandom_range(0, 4) == 0) add_byte($urandom_range(0, 1) ? CH_UNDER : CH_DOT);
            if ($urandom_range(0, 9) < 5) add_byte(CH_SPACE);
        end else if (sel < 72) begin
            add_byte(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
                r = $urandom_range(0, 19);
                if (r == 0) ch = CH_CR;
                else if (r == 1) ch = CH_LF;
                else if (r == 2) ch = 8'($urandom_range(128, 255));
                else begin
                    ch = 8'($urandom_range(32, 126));
                    if (ch == CH_QUOTE) ch = CH_SPACE;
                end
                add_byte(ch);
            end
            add_byte(($urandom_range(0, 6) == 0) ? CH_NUL : CH_QUOTE);
        end else if (sel < 84) begin
            r = $urandom_range(0, 4);
            if (r == 0) add_byte(CH_SPACE);
            else if (r == 1) add_byte(CH_TAB);
            else if (r == 2) add_byte(CH_CR);
            else if (r == 3) add_byte(CH_LF);
            else begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        end else if (sel < 88) begin
            add_byte(CH_NUL);
        end else begin
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // input side: a byte is taken at a rising edge with valid high and stall low
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            lex_byte(i_char_code);
            byte_taken = 1'b1;
            bytes_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !byte_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (byte_queue.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                head_byte = byte_queue[0];
                if (head_byte.drain && settle_cnt < SETTLE_CYCLES) begin
                    // hold off until every record so far has come out
                    i_valid <= 1'b0;
                    settle_cnt = (tokens_due.size() != 0) ? 0 : settle_cnt + 1;
                end else begin
                    head_byte = byte_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_char_code <= head_byte.ch;
                    settle_cnt = 0;
                    send_gap   = next_gap(send_quiet);
                end
            end
        end
        byte_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = next_gap(sink_quiet);
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_rec.kind       = o_token_kind;
            seen_rec.start_pos  = o_start_position;
            seen_rec.end_pos    = o_end_position;
            seen_rec.start_line = o_start_line;
            seen_rec.start_col  = o_start_column;
            seen_rec.end_line   = o_end_line;
            seen_rec.end_col    = o_end_column;
            seen_rec.diag       = o_diag_code;
            seen_rec.last       = o_last_of_run;
            records_seen++;
            kinds_seen[o_token_kind] = 1'b1;
            if (tokens_due.size() == 0) begin
                report_mismatch({"unexpected token record: ", rec_text(seen_rec)});
            end else begin
                want_rec = tokens_due.pop_front();
                if (seen_rec !== want_rec)
                    report_mismatch({"token mismatch: expected ", rec_text(want_rec),
                                     " got ", rec_text(seen_rec)});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main
        int  rand_start;
        int  k;
        int  n_kinds;
        logic mid_drain_done;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_char_code = 8'h00;
        mid_drain_done = 1'b0;
        for (k = 0; k < 32; k++) kinds_seen[k] = 1'b0;

        // directed: every operator, lookahead cases, crlf, illegal bytes, open string at eof
        add_text("+-*/(){x_1=7_.5,\"q\n\"}\t8.y");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_text("#");
        add_byte(8'hFF);
        add_text("\"z");
        add_byte(CH_NUL);

        rand_start    = byte_queue.size();
        drain_pending = 1'b1;
        while (byte_queue.size() < rand_start + RANDOM_BYTES) begin
            if (!mid_drain_done && byte_queue.size() >= rand_start + RANDOM_BYTES / 2) begin
                drain_pending  = 1'b1;
                mid_drain_done = 1'b1;
            end
            add_random_token();
        end

        // closing text with a number, a string and a crlf before the end of text
        add_byte(CH_NUL);
        add_text("x=1.5 \"s\"");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("y");
        add_byte(CH_NUL);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        n_kinds = 0;
        for (k = 0; k <= stt_pkg::TK_UNKNOWN; k++) if (kinds_seen[k]) n_kinds++;
        $display("tokenizer run: %0d source bytes, %0d token records, %0d of %0d token kinds",
                 bytes_sent, records_seen, n_kinds, stt_pkg::TK_UNKNOWN + 1);
        $display("lookahead, crlf, open string and illegal bytes under random stalls, %0d %s",
                 mismatches, "mismatches");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[source_text_tokenizer_core.f]
src/stt_pkg.sv
src/stt_front.sv
src/stt_queue.sv
src/stt_back.sv
src/source_text_tokenizer_core.sv
sim/tb.sv
